// File: rtl/tri3_pkg.sv
// ----------------------------------------------------------------------------
// tri3_pkg
// Shared widths and constants for the three-anchor trilateration pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tri3_pkg;

    // field widths
    localparam int CW      = 24;   // coordinate, signed
    localparam int RGW     = 23;   // range, unsigned
    localparam int TOL_W   = 8;    // tolerance register
    localparam logic [TOL_W-1:0] TOL_RST = 8'd3;

    // stream widths
    localparam int S_TDATA_W = 216;
    localparam int M_TDATA_W = 48;

    // datapath widths
    localparam int NEW     = 27;   // near-equal compare
    localparam int DXW     = 25;   // coordinate difference
    localparam int SQW     = 47;   // square of a coordinate
    localparam int PW      = 49;   // x^2 + y^2 - r^2 and its differences
    localparam int LOW     = 24;   // low part of a split multiplicand
    localparam int HIW     = PW - LOW;
    localparam int PPW     = 50;   // 25 x 25 partial product
    localparam int PRW     = 74;   // full n * d product
    localparam int NUMW    = 75;   // Cramer numerator
    localparam int DETW    = 51;   // Cramer determinant
    localparam int DENW    = 52;   // 2 * |det|
    localparam int MAGW    = 75;   // numerator magnitude

    // divider
    localparam int QBITS   = 25;   // quotient bits below the overflow bound
    localparam int REMW    = 78;
    localparam int DIV_LAT = QBITS + 2;

    // front pipeline stages in the top level
    localparam int FRONT   = 8;
    localparam int TOTAL   = FRONT + DIV_LAT;

    localparam logic signed [CW-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [CW-1:0] COORD_MIN = 24'sh800000;

endpackage

`default_nettype wire

// File: rtl/tri3_div.sv
// ----------------------------------------------------------------------------
// tri3_div
// Pipelined restoring divider: magnitude / denominator, one quotient bit per
// stage, rounded to nearest (ties away from zero), signed and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module tri3_div import tri3_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic                 i_neg,
    input  wire logic [MAGW-1:0]      i_mag,
    input  wire logic [DENW-1:0]      i_den,
    output logic signed [CW-1:0]      o_quot
);

    logic [REMW-1:0]  r_rem [QBITS+1];
    logic [DENW-1:0]  r_den [QBITS+1];
    logic [QBITS-1:0] r_q   [QBITS+1];
    logic             r_ovf [QBITS+1];
    logic             r_neg [QBITS+1];
    logic signed [CW-1:0] r_quot;

    // entry stage: quotient of 2^QBITS or more always saturates
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= REMW'(i_mag);
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= REMW'(i_mag) >= (REMW'(i_den) << QBITS);
            r_neg[0] <= i_neg;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar g = 1; g <= QBITS; g++) begin : g_step
        logic [REMW-1:0] n_sub;
        logic            n_ge;
        assign n_sub = REMW'(r_den[g-1]) << (QBITS - g);
        assign n_ge  = r_rem[g-1] >= n_sub;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_ge ? (r_rem[g-1] - n_sub) : r_rem[g-1];
                r_q[g]   <= {r_q[g-1][QBITS-2:0], n_ge};
                r_den[g] <= r_den[g-1];
                r_ovf[g] <= r_ovf[g-1];
                r_neg[g] <= r_neg[g-1];
            end
        end
    end

    // rounding and saturation
    logic              n_rnd;
    logic [QBITS:0]    n_qr;
    logic signed [CW-1:0] n_quot;

    always_comb begin
        n_rnd = {r_rem[QBITS][REMW-2:0], 1'b0} >= REMW'(r_den[QBITS]);
        n_qr  = (QBITS+1)'(r_q[QBITS]) + (QBITS+1)'(n_rnd);
        if (r_neg[QBITS]) begin
            if (r_ovf[QBITS] || n_qr > (QBITS+1)'(8388608))
                n_quot = COORD_MIN;
            else
                n_quot = -$signed(n_qr[CW-1:0]);
        end else begin
            if (r_ovf[QBITS] || n_qr > (QBITS+1)'(8388607))
                n_quot = COORD_MAX;
            else
                n_quot = $signed(n_qr[CW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= n_quot;
        end
    end

    assign o_quot = r_quot;

endmodule

`default_nettype wire

// File: rtl/trilateration_three_anchors.sv
// ----------------------------------------------------------------------------
// trilateration_three_anchors
// 2D position from three anchors and ranges by Cramer's rule, fixed point.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       anchors a, b, c (x, y, range)
//  m_*       out  m_tvalid / m_tready       target x, y; tuser = found
//  i_cfg_*   in   i_cfg_valid / o_cfg_ready equal_tolerance
//
//  The pipeline has 8 arithmetic stages, then 27 divider stages.
//  One item per cycle; the whole pipeline advances on a common enable.
//  The pipeline holds when the output register is full and not taken.
//  Synchronous active-low reset clears the valid bits and sets the tolerance to 3.
// ----------------------------------------------------------------------------
`default_nettype none

module trilateration_three_anchors import tri3_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // config
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [TOL_W-1:0]       i_cfg_data,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // a_x, a_y, a_range, b_x, b_y, b_range, c_x, c_y, c_range, 3 pad bits
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // output stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // target_x, target_y
    output logic [M_TDATA_W-1:0]        m_tdata,
    // found
    output logic                        m_tuser
);

    logic             w_en;
    logic [TOL_W-1:0] r_tol;
    logic [TOTAL-1:0] r_vld;

    assign w_en        = !r_vld[TOTAL-1] || m_tready;
    assign s_tready    = w_en;
    assign o_cfg_ready = 1'b1;

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RST;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOTAL-2:0], s_tvalid};
        end
    end

    function automatic logic near_eq(input logic signed [CW-1:0] a,
                                     input logic signed [CW-1:0] b,
                                     input logic [TOL_W-1:0] t);
        logic signed [NEW-1:0] d;
        logic signed [NEW-1:0] ts;
        d  = NEW'(a) - NEW'(b);
        ts = $signed(NEW'(t));
        return (d < ts) && (-d < ts);
    endfunction

    // S1: unpack, near-equal tests for the reorder
    logic signed [CW-1:0]  n1_x [3];
    logic signed [CW-1:0]  n1_y [3];
    logic [RGW-1:0]        n1_r [3];
    logic signed [CW-1:0]  r1_x [3];
    logic signed [CW-1:0]  r1_y [3];
    logic [RGW-1:0]        r1_r [3];
    logic                  r1_eij, r1_eik;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n1_x[a] = $signed(s_tdata[a*71 +: CW]);
            n1_y[a] = $signed(s_tdata[a*71+24 +: CW]);
            n1_r[a] = s_tdata[a*71+48 +: RGW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x   <= n1_x;
            r1_y   <= n1_y;
            r1_r   <= n1_r;
            r1_eij <= near_eq(n1_x[0], n1_x[1], r_tol);
            r1_eik <= near_eq(n1_x[0], n1_x[2], r_tol);
        end
    end

    // S2: reorder anchors, squares
    function automatic logic [SQW-1:0] sq(input logic signed [CW-1:0] v);
        logic signed [2*CW-1:0] p;
        p = v * v;
        return SQW'(p);
    endfunction

    logic signed [CW-1:0]  n2_x [3];
    logic signed [CW-1:0]  n2_y [3];
    logic [RGW-1:0]        n2_r [3];
    logic signed [CW-1:0]  r2_x [3];
    logic signed [CW-1:0]  r2_y [3];
    logic [SQW-1:0]        r2_xs [3];
    logic [SQW-1:0]        r2_ys [3];
    logic [SQW-1:0]        r2_rs [3];

    always_comb begin
        n2_x = r1_x;
        n2_y = r1_y;
        n2_r = r1_r;
        if (r1_eij) begin
            n2_x[0] = r1_x[2]; n2_y[0] = r1_y[2]; n2_r[0] = r1_r[2];
            n2_x[2] = r1_x[0]; n2_y[2] = r1_y[0]; n2_r[2] = r1_r[0];
        end else if (r1_eik) begin
            n2_x[0] = r1_x[1]; n2_y[0] = r1_y[1]; n2_r[0] = r1_r[1];
            n2_x[1] = r1_x[0]; n2_y[1] = r1_y[0]; n2_r[1] = r1_r[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_x <= n2_x;
            r2_y <= n2_y;
            for (int a = 0; a < 3; a++) begin
                r2_xs[a] <= sq(n2_x[a]);
                r2_ys[a] <= sq(n2_y[a]);
                r2_rs[a] <= SQW'(n2_r[a] * n2_r[a]);
            end
        end
    end

    // S3: power terms, differences, degenerate tests
    logic signed [PW-1:0]  r3_p [3];
    logic signed [DXW-1:0] r3_dx1, r3_dx2, r3_dy1, r3_dy2;
    logic                  r3_ne;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r3_p[a] <= $signed(PW'(r2_xs[a])) + $signed(PW'(r2_ys[a]))
                         - $signed(PW'(r2_rs[a]));
            end
            r3_dx1 <= DXW'(r2_x[0]) - DXW'(r2_x[1]);
            r3_dx2 <= DXW'(r2_x[0]) - DXW'(r2_x[2]);
            r3_dy1 <= DXW'(r2_y[0]) - DXW'(r2_y[1]);
            r3_dy2 <= DXW'(r2_y[0]) - DXW'(r2_y[2]);
            r3_ne  <= near_eq(r2_x[0], r2_x[1], r_tol) ||
                      near_eq(r2_x[0], r2_x[2], r_tol);
        end
    end

    // S4: right-hand sides, determinant products
    logic signed [PW-1:0]  r4_n1, r4_n2;
    logic signed [PPW-1:0] r4_pd1, r4_pd2;
    logic signed [DXW-1:0] r4_dx1, r4_dx2, r4_dy1, r4_dy2;
    logic                  r4_ok;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_n1  <= r3_p[0] - r3_p[1];
            r4_n2  <= r3_p[0] - r3_p[2];
            r4_pd1 <= r3_dx1 * r3_dy2;
            r4_pd2 <= r3_dx2 * r3_dy1;
            r4_dx1 <= r3_dx1;
            r4_dx2 <= r3_dx2;
            r4_dy1 <= r3_dy1;
            r4_dy2 <= r3_dy2;
            r4_ok  <= !r3_ne && (r3_dx1 != '0) && (r3_dx2 != '0);
        end
    end

    // S5: determinant, split partial products of n * d
    function automatic logic signed [PPW-1:0] mul_lo(input logic signed [PW-1:0] n,
                                                     input logic signed [DXW-1:0] d);
        return $signed({1'b0, n[LOW-1:0]}) * d;
    endfunction

    function automatic logic signed [PPW-1:0] mul_hi(input logic signed [PW-1:0] n,
                                                     input logic signed [DXW-1:0] d);
        return $signed(n[PW-1:LOW]) * d;
    endfunction

    logic signed [DETW-1:0] r5_det;
    logic signed [PPW-1:0]  r5_lo [4];
    logic signed [PPW-1:0]  r5_hi [4];
    logic                   r5_ok;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_det   <= DETW'(r4_pd1) - DETW'(r4_pd2);
            r5_lo[0] <= mul_lo(r4_n1, r4_dy2);
            r5_hi[0] <= mul_hi(r4_n1, r4_dy2);
            r5_lo[1] <= mul_lo(r4_n2, r4_dy1);
            r5_hi[1] <= mul_hi(r4_n2, r4_dy1);
            r5_lo[2] <= mul_lo(r4_n2, r4_dx1);
            r5_hi[2] <= mul_hi(r4_n2, r4_dx1);
            r5_lo[3] <= mul_lo(r4_n1, r4_dx2);
            r5_hi[3] <= mul_hi(r4_n1, r4_dx2);
            r5_ok    <= r4_ok;
        end
    end

    // S6: recombine products
    logic signed [PRW-1:0]  r6_t [4];
    logic signed [DETW-1:0] r6_det;
    logic                   r6_ok;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r6_t[k] <= (PRW'(r5_hi[k]) <<< LOW) + PRW'(r5_lo[k]);
            end
            r6_det <= r5_det;
            r6_ok  <= r5_ok && (r5_det != '0);
        end
    end

    // S7: Cramer numerators
    logic signed [NUMW-1:0] r7_nx, r7_ny;
    logic signed [DETW-1:0] r7_det;
    logic                   r7_ok;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_nx  <= NUMW'(r6_t[0]) - NUMW'(r6_t[1]);
            r7_ny  <= NUMW'(r6_t[2]) - NUMW'(r6_t[3]);
            r7_det <= r6_det;
            r7_ok  <= r6_ok;
        end
    end

    // S8: signs and magnitudes for the dividers
    logic [MAGW-1:0] r8_mx, r8_my;
    logic [DENW-1:0] r8_den;
    logic            r8_nx, r8_ny;
    logic            r8_ok;
    logic            n8_dn;

    assign n8_dn = r7_det[DETW-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_mx  <= r7_nx[NUMW-1] ? MAGW'(-r7_nx) : MAGW'(r7_nx);
            r8_my  <= r7_ny[NUMW-1] ? MAGW'(-r7_ny) : MAGW'(r7_ny);
            r8_den <= n8_dn ? (DENW'(-r7_det) << 1) : (DENW'(r7_det) << 1);
            r8_nx  <= r7_nx[NUMW-1] ^ n8_dn;
            r8_ny  <= r7_ny[NUMW-1] ^ n8_dn;
            r8_ok  <= r7_ok;
        end
    end

    // dividers
    logic signed [CW-1:0] w_qx, w_qy;

    tri3_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_neg  (r8_nx),
        .i_mag  (r8_mx),
        .i_den  (r8_den),
        .o_quot (w_qx)
    );

    tri3_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_neg  (r8_ny),
        .i_mag  (r8_my),
        .i_den  (r8_den),
        .o_quot (w_qy)
    );

    // found flag travels beside the dividers
    logic [DIV_LAT-1:0] r_okp;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_okp <= {r_okp[DIV_LAT-2:0], r8_ok};
        end
    end

    // output
    assign m_tvalid = r_vld[TOTAL-1];
    assign m_tuser  = r_okp[DIV_LAT-1];
    assign m_tdata  = r_okp[DIV_LAT-1] ? {w_qy, w_qx} : '0;

    // checks
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output state");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("degenerate result carries a nonzero point");

    a_vld_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |=> r_vld[1] == $past(r_vld[0]))
        else $error("valid bit lost between stages");

endmodule

`default_nettype wire

// File: verif/trilateration_three_anchors_tb.sv
// ----------------------------------------------------------------------------
// trilateration_three_anchors_tb
// Self-checking bench: streams anchor triples into the block, predicts each
// located point and found flag in the bench, and compares every result item.
// Covers the reordering and degenerate-geometry paths, saturation, several
// tolerance settings, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module trilateration_three_anchors_tb import tri3_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = TOTAL + 10;
    localparam int LONG_HOLD      = 300;

    typedef struct {
        logic signed [CW-1:0] x [3];
        logic signed [CW-1:0] y [3];
        logic [RGW-1:0]       rng [3];
    } t_fix;

    typedef struct {
        logic signed [CW-1:0] tx;
        logic signed [CW-1:0] ty;
        logic                 found;
    } t_point;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [TOL_W-1:0]      i_cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    t_point          expected_points [$];
    logic [TOL_W-1:0] tolerance = TOL_RST;
    int              errors = 0;
    int              idle_cycles = 0;
    bit              no_idle = 1'b0;
    int              hold_id = 0;
    int              last_hold_id = 0;
    int              hold_cnt = 0;
    int              stall_cnt = 0;

    trilateration_three_anchors u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor
    function automatic bit x_close(longint p, longint q);
        longint t;
        t = longint'(tolerance);
        return (p - q) < t && (q - p) < t;
    endfunction

    // rounded quotient, ties away from zero, clamped to the coordinate range
    function automatic logic signed [CW-1:0] div_clamp(logic signed [127:0] num,
                                                       longint den);
        logic [127:0] mn, md, q, r;
        bit neg;
        neg = (num < 0) != (den < 0);
        mn = num < 0 ? -num : num;
        md = 128'(den < 0 ? -den : den);
        q = mn / md;
        r = mn % md;
        if (2 * r >= md) q = q + 128'd1;
        if (neg) return q > 128'd8388608 ? COORD_MIN : CW'(-q);
        return q > 128'd8388607 ? COORD_MAX : CW'(q);
    endfunction

    function automatic t_point locate(t_fix f);
        longint x [3], y [3], r [3], t;
        longint dx1, dx2, dy1, dy2, n1, n2, det;
        logic signed [127:0] w1, w2, w3, w4;
        t_point p;
        for (int k = 0; k < 3; k++) begin
            x[k] = longint'(f.x[k]);
            y[k] = longint'(f.y[k]);
            r[k] = longint'({1'b0, f.rng[k]});
        end
        // anchor reordering
        if (x_close(x[0], x[1])) begin
            t = x[0]; x[0] = x[2]; x[2] = t;
            t = y[0]; y[0] = y[2]; y[2] = t;
            t = r[0]; r[0] = r[2]; r[2] = t;
        end else if (x_close(x[0], x[2])) begin
            t = x[0]; x[0] = x[1]; x[1] = t;
            t = y[0]; y[0] = y[1]; y[1] = t;
            t = r[0]; r[0] = r[1]; r[1] = t;
        end
        dx1 = x[0] - x[1];
        dx2 = x[0] - x[2];
        dy1 = y[0] - y[1];
        dy2 = y[0] - y[2];
        n1 = x[0]*x[0] - x[1]*x[1] + y[0]*y[0] - y[1]*y[1] - r[0]*r[0] + r[1]*r[1];
        n2 = x[0]*x[0] - x[2]*x[2] + y[0]*y[0] - y[2]*y[2] - r[0]*r[0] + r[2]*r[2];
        det = dx1*dy2 - dx2*dy1;
        p.found = !x_close(x[0], x[1]) && !x_close(x[0], x[2]) &&
                  dx1 != 0 && dx2 != 0 && det != 0;
        p.tx = '0;
        p.ty = '0;
        if (p.found) begin
            w1 = n1; w2 = dy2; w3 = n2; w4 = dy1;
            p.tx = div_clamp(w1 * w2 - w3 * w4, 2 * det);
            w1 = dx1; w2 = n2; w3 = dx2; w4 = n1;
            p.ty = div_clamp(w1 * w2 - w3 * w4, 2 * det);
        end
        return p;
    endfunction

    // ---------------------------------------------------------------- helpers
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 80) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_fix(t_fix f);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        for (int k = 0; k < 3; k++) begin
            d[k*71 +: 24]      = f.x[k];
            d[k*71 + 24 +: 24] = f.y[k];
            d[k*71 + 48 +: 23] = f.rng[k];
        end
        return d;
    endfunction

    function automatic t_fix noise_fix();
        t_fix f;
        for (int k = 0; k < 3; k++) begin
            f.x[k] = CW'($urandom);
            f.y[k] = CW'($urandom);
            f.rng[k] = RGW'($urandom);
        end
        return f;
    endfunction

    // anchors around a target with ranges that fit it, optionally perturbed
    function automatic t_fix geo_fix(int spread, int jitter);
        t_fix f;
        int tx, ty;
        real dx, dy;
        tx = $signed($urandom_range(0, 2*spread)) - spread;
        ty = $signed($urandom_range(0, 2*spread)) - spread;
        for (int k = 0; k < 3; k++) begin
            f.x[k] = CW'($signed($urandom_range(0, 2*spread)) - spread);
            f.y[k] = CW'($signed($urandom_range(0, 2*spread)) - spread);
            dx = f.x[k] - tx;
            dy = f.y[k] - ty;
            f.rng[k] = RGW'(int'($sqrt(dx*dx + dy*dy)) + $urandom_range(0, jitter));
        end
        return f;
    endfunction

    function automatic t_fix mk(int ax, int ay, int ar, int bx, int by, int br,
                                int cx, int cy, int cr);
        t_fix f;
        f.x[0] = CW'(ax); f.y[0] = CW'(ay); f.rng[0] = RGW'(ar);
        f.x[1] = CW'(bx); f.y[1] = CW'(by); f.rng[1] = RGW'(br);
        f.x[2] = CW'(cx); f.y[2] = CW'(cy); f.rng[2] = RGW'(cr);
        return f;
    endfunction

    // ---------------------------------------------------------------- drivers
    task automatic send_fix(t_fix f);
        int g;
        s_tvalid <= 1'b1;
        s_tdata  <= pack_fix(f);
        do @(posedge i_clk); while (!s_tready);
        expected_points.push_back(locate(f));
        if (!no_idle && $urandom_range(0, 99) < 35) begin
            g = gap_len();
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tolerance = v;
        i_cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_directed();
        send_fix(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_fix(mk(0, 0, 2560, 2560, 0, 2560, 0, 2560, 2560));
        send_fix(mk(8388607, 8388607, 8388607, -8388608, -8388608, 0,
                    8388607, -8388608, 8388607));
        send_fix(mk(-8388608, 8388607, 0, 8388607, 8388607, 8388607,
                    0, -8388608, 4194304));
        // x of a within the tolerance of x of b: a and c trade places
        send_fix(mk(1000, 0, 1500, 1001, 900, 800, -700, 300, 1200));
        // x of a within the tolerance of x of c: a and b trade places
        send_fix(mk(500, 0, 700, -900, 400, 1200, 502, 1000, 1000));
        // still within the tolerance after the swap
        send_fix(mk(100, 0, 50, 101, 300, 60, 99, -400, 70));
        // collinear anchors, slopes equal
        send_fix(mk(0, 0, 100, 256, 256, 200, 512, 512, 300));
        // nearly collinear: quotient far beyond range
        send_fix(mk(0, 0, 8388607, 4096, 4096, 0, 8192, 8193, 8388607));
        send_fix(mk(0, 0, 0, 4096, 4096, 8388607, 8192, 8193, 0));
        // small values whose quotients exercise the rounding
        send_fix(mk(0, 0, 1, 5, 0, 2, 0, 7, 3));
        send_fix(mk(0, 0, 3, -5, 0, 2, 0, -7, 1));
        send_fix(mk(-4, 3, 7, 9, -2, 5, 6, 11, 4));
        send_fix(mk(7, -7, 0, -7, 7, 0, 20, 20, 0));
        for (int k = 0; k < 6; k++) send_fix(noise_fix());
    endtask

    task automatic run_random(int count);
        t_fix f;
        int sel, d;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                f = geo_fix($urandom_range(0, 3) == 0 ? 2000 : 1000000, 0);
            end else if (sel < 70) begin
                f = geo_fix(1000000, 500);
            end else if (sel < 85) begin
                // x values that straddle the tolerance
                f = geo_fix(100000, 2);
                d = int'(tolerance) + 2;
                f.x[$urandom_range(1, 2)] =
                    CW'(f.x[0] + $signed($urandom_range(0, 2*d)) - d);
                if ($urandom_range(0, 1))
                    f.x[1] = CW'(f.x[2] + $signed($urandom_range(0, 2*d)) - d);
            end else begin
                f = noise_fix();
            end
            send_fix(f);
        end
    endtask

    task automatic test_tolerance();
        write_tolerance(8'd0);
        send_fix(mk(300, 0, 200, 300, 500, 100, -200, 100, 50));
        send_fix(mk(300, 0, 200, 301, 500, 100, -200, 100, 50));
        run_random(60);
        write_tolerance(8'd255);
        send_fix(mk(0, 0, 2000, 254, 900, 1000, 3000, -700, 1500));
        send_fix(mk(0, 0, 2000, 255, 900, 1000, 3000, -700, 1500));
        run_random(60);
        write_tolerance(8'd1);
        run_random(40);
        write_tolerance(8'($urandom_range(2, 254)));
        run_random(60);
        write_tolerance(TOL_RST);
    endtask

    task automatic test_backpressure();
        no_idle = 1'b1;
        @(posedge i_clk);
        hold_id = hold_id + 1;
        run_random(80);
        no_idle = 1'b0;
    endtask

    // ---------------------------------------------------------------- receiver
    always @(posedge i_clk) begin
        if (hold_id != last_hold_id) begin
            last_hold_id = hold_id;
            hold_cnt = LONG_HOLD;
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt = stall_cnt - 1;
            m_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 20) begin
            stall_cnt = gap_len() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- checker
    always @(posedge i_clk) begin
        t_point e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected result item x=%0d y=%0d found=%0b", $time,
                         $signed(m_tdata[23:0]), $signed(m_tdata[47:24]), m_tuser);
                errors++;
            end else begin
                e = expected_points.pop_front();
                if (m_tdata[23:0] !== e.tx) begin
                    $display("%0t: target_x expected %0d actual %0d", $time, e.tx,
                             $signed(m_tdata[23:0]));
                    errors++;
                end
                if (m_tdata[47:24] !== e.ty) begin
                    $display("%0t: target_y expected %0d actual %0d", $time, e.ty,
                             $signed(m_tdata[47:24]));
                    errors++;
                end
                if (m_tuser !== e.found) begin
                    $display("%0t: found expected %0b actual %0b", $time, e.found,
                             m_tuser);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_tolerance();
        test_backpressure();
        run_random(330);
        wait_drained();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/tri3_pkg.sv
rtl/tri3_div.sv
rtl/trilateration_three_anchors.sv
verif/trilateration_three_anchors_tb.sv
